FILE: rtl/sdrq_pkg.sv
package sdrq_pkg;

   localparam int POS_W = 48;

   typedef logic [POS_W-1:0] pos_type;

   // Request operation carried in tuser
   typedef enum logic {
      OP_ADD      = 1'b0,
      OP_DISPATCH = 1'b1
   } op_type;

   // Per-cell load command for the apply step
   typedef enum logic [1:0] {
      CMD_HOLD      = 2'd0,
      CMD_LOAD_REQ  = 2'd1,
      CMD_LOAD_PREV = 2'd2,
      CMD_LOAD_NEXT = 2'd3
   } cell_cmd_type;

   typedef struct packed {
      logic         calc_dist;
      logic         calc_hit;
      cell_cmd_type cmd;
   } cell_ctrl_type;

   function automatic pos_type abs_diff(input pos_type a, input pos_type b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

FILE: rtl/seek_distance_request_queue_top.sv
// Each request transaction walks the distance, compare, slot-scan and apply steps of
//   the cell row; its result is registered when the apply step fires. A new request
//   is accepted only once the previous one has left the apply step.
// A pending result may stall the apply step until the result slot frees.
// Reset: synchronous, active high; queue empty, last position zero, no result
//   pending. Entry contents are not cleared.
module seek_distance_request_queue_top
   import sdrq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
)
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [47:0] request_position
   input  logic [0:0]  req_tuser,   // [0] operation (0 add, 1 dispatch)
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [47:0] dispatched_position
   output logic [1:0]  rsp_tuser    // [0] dispatch_valid, [1] add_rejected
);

   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SCAN_N = $clog2(QUEUE_DEPTH);

   // One-hot sequencer: each request walks the cell row in four steps
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIST  = 5'b00010,
      ST_CMP   = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_APPLY = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic                 op_ff;
   pos_type              pos_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   pos_type              last_ff, last_in;
   pos_type              dreq_last_ff;
   pos_type              dhead_last_ff;
   logic                 front_ff;
   logic [QUEUE_DEPTH-1:0] le_ff, le_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   pos_type              rsp_pos_ff;
   logic                 rsp_dv_ff;
   logic                 rsp_rej_ff;

   pos_type              cell_value [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_hit;
   logic [QUEUE_DEPTH-1:0] next_valid;
   logic [QUEUE_DEPTH-1:0] beyond_tail;
   cell_ctrl_type        cell_ctrl [QUEUE_DEPTH];

   logic                 accept;
   logic                 apply_fire;
   logic                 is_full;
   logic                 is_empty;
   logic                 do_add;
   logic                 do_pop;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign apply_fire = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_tready);
   assign is_full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign is_empty   = (count_ff == '0);
   assign do_add     = (op_ff == OP_ADD) && !is_full;
   assign do_pop     = (op_ff == OP_DISPATCH) && !is_empty;

   // --- cell row ---
   for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
      pos_type prev_v;
      pos_type next_v;

      if (j == 0) begin : g_first
         assign prev_v = '0;
      end else begin : g_mid_prev
         assign prev_v = cell_value[j-1];
      end
      if (j == QUEUE_DEPTH - 1) begin : g_last
         assign next_v = '0;
      end else begin : g_mid_next
         assign next_v = cell_value[j+1];
      end

      // cell j has a successor inside the queue; cell j lies at or past the tail
      assign next_valid[j]  = (CNT_W'(j + 1) < count_ff);
      assign beyond_tail[j] = (CNT_W'(j) >= count_ff);

      always_comb begin
         cell_ctrl[j].calc_dist = (state_ff == ST_DIST);
         cell_ctrl[j].calc_hit  = (state_ff == ST_CMP);
         cell_ctrl[j].cmd       = CMD_HOLD;
         if (apply_fire && do_pop) begin
            cell_ctrl[j].cmd = CMD_LOAD_NEXT;
         end else if (apply_fire && do_add) begin
            if (j > 0 && le_ff[(j > 0) ? j-1 : 0]) begin
               cell_ctrl[j].cmd = CMD_LOAD_PREV;
            end else if (le_ff[j]) begin
               cell_ctrl[j].cmd = CMD_LOAD_REQ;
            end
         end
      end

      sdrq_cell u_cell (
         .clock      (clock),
         .prev_value (prev_v),
         .next_value (next_v),
         .next_valid (next_valid[j]),
         .req_pos    (pos_ff),
         .ctrl       (cell_ctrl[j]),
         .value      (cell_value[j]),
         .hit        (cell_hit[j])
      );
   end

   // --- slot scan ---
   // le[j]: insertion slot is at or below j. A hit in cell k puts the slot at k+1,
   // so cell j sees hits from cells below j-1 inclusive; prefix OR in log steps.
   always_comb begin
      logic [QUEUE_DEPTH-1:0] p;
      p = cell_hit << 1;
      for (int s = 0; s < SCAN_N; s++) begin
         p = p | (p << (1 << s));
      end
      le_in = p | beyond_tail | {QUEUE_DEPTH{front_ff}};
   end

   // --- sequencer and queue bookkeeping ---
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      last_in  = last_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_DIST;
         ST_DIST:  state_in = ST_CMP;
         ST_CMP:   state_in = ST_SCAN;
         ST_SCAN:  state_in = ST_APPLY;
         ST_APPLY: begin
            if (apply_fire) begin
               state_in = ST_IDLE;
               if (do_add) begin
                  count_in = count_ff + 1'b1;
               end else if (do_pop) begin
                  count_in = count_ff - 1'b1;
                  last_in  = cell_value[0];
               end
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (apply_fire)                 rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_tuser[0];
         pos_ff <= req_tdata;
      end
      // front test against the last dispatched position, strict
      if (state_ff == ST_DIST) begin
         dreq_last_ff  <= abs_diff(pos_ff, last_ff);
         dhead_last_ff <= abs_diff(cell_value[0], last_ff);
      end
      if (state_ff == ST_CMP) begin
         front_ff <= (dreq_last_ff < dhead_last_ff);
      end
      if (state_ff == ST_SCAN) begin
         le_ff <= le_in;
      end
      if (apply_fire) begin
         rsp_pos_ff <= do_pop ? cell_value[0] : '0;
         rsp_dv_ff  <= do_pop;
         rsp_rej_ff <= (op_ff == OP_ADD) && is_full;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pos_ff;
   assign rsp_tuser  = {rsp_rej_ff, rsp_dv_ff};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count beyond queue depth");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_dv_ff && rsp_rej_ff))
      else $error("result both dispatched and rejected");

   a_zero_when_no_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_dv_ff) |-> (rsp_pos_ff == '0))
      else $error("position returned without a dispatch");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (apply_fire && do_pop) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("dispatch did not shrink the queue");
`endif

endmodule

FILE: rtl/sdrq_cell.sv
module sdrq_cell
   import sdrq_pkg::*;
(
   input  logic          clock,
   input  pos_type       prev_value,
   input  pos_type       next_value,
   input  logic          next_valid,
   input  pos_type       req_pos,
   input  cell_ctrl_type ctrl,
   output pos_type       value,
   output logic          hit
);

   pos_type value_ff, value_in;
   pos_type d_next_ff;
   pos_type d_req_ff;
   logic    hit_ff;

   always_comb begin
      case (ctrl.cmd)
         CMD_LOAD_REQ:  value_in = req_pos;
         CMD_LOAD_PREV: value_in = prev_value;
         CMD_LOAD_NEXT: value_in = next_value;
         default:       value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (ctrl.calc_dist) begin
         d_next_ff <= abs_diff(value_ff, next_value);
         d_req_ff  <= abs_diff(value_ff, req_pos);
      end
      // strict compare: ties never insert here
      if (ctrl.calc_hit) begin
         hit_ff <= next_valid && (d_next_ff > d_req_ff);
      end
   end

   assign value = value_ff;
   assign hit   = hit_ff;

endmodule

FILE: verif/seek_distance_request_queue_top_tb.sv
`timescale 1ns / 1ps

module seek_distance_request_queue_top_tb;
   import sdrq_pkg::*;

   localparam int      DEPTH    = 16;
   localparam pos_type POS_MAX  = 48'hFFFF_FFFF_FFFF;
   localparam int      N_RANDOM = 1800;
   localparam int      MAX_SHOWN = 40;   // mismatch lines printed before going quiet

   // one result transaction, as the block reports it
   typedef struct packed {
      pos_type position;
      logic    dispatched;
      logic    rejected;
   } seek_result_type;

   // one row of the directed table; want is only used when typed is set
   typedef struct packed {
      op_type          op;
      pos_type         pos;
      logic            typed;
      seek_result_type want;
   } stim_row_type;

   localparam seek_result_type RES_NONE   = '{position: '0, dispatched: 1'b0, rejected: 1'b0};
   localparam seek_result_type RES_REFUSE = '{position: '0, dispatched: 1'b0, rejected: 1'b1};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;     // [47:0] request_position
   logic [0:0]  req_tuser = '0;     // [0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;          // [47:0] dispatched_position
   logic [1:0]  rsp_tuser;          // [0] dispatch_valid, [1] add_rejected

   // predictor state: the ordered seek queue and the last position served
   pos_type seek_queue [DEPTH];
   int      seek_count;
   pos_type last_served;

   seek_result_type pending_results [$];
   stim_row_type    directed [$];

   int  fail_count = 0;
   bit  steady = 1'b0;              // set: neither side idles
   int  n_front, n_middle, n_tail, n_refused, n_pops, n_empty_pops;

   seek_distance_request_queue_top #(
      .QUEUE_DEPTH (DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   function automatic pos_type seek_span(input pos_type a, input pos_type b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Shortest-seek insertion: front if nearer the last served position than the
   // head is, else after the first entry nearer the request than its own
   // successor, else tail. Ties never win a front or mid-queue slot.
   function automatic seek_result_type schedule_request(input op_type op, input pos_type pos);
      seek_result_type r;
      int              slot;
      r    = RES_NONE;
      slot = -1;
      if (op == OP_ADD) begin
         if (seek_count >= DEPTH) begin
            r.rejected = 1'b1;
            n_refused++;
         end else begin
            if (seek_count == 0) begin
               slot = 0;
               n_tail++;
            end else if (seek_span(pos, last_served) < seek_span(seek_queue[0], last_served)) begin
               slot = 0;
               n_front++;
            end else begin
               for (int i = 0; i + 1 < seek_count && slot < 0; i++)
                  if (seek_span(seek_queue[i], seek_queue[i+1]) > seek_span(seek_queue[i], pos))
                     slot = i + 1;
               if (slot < 0) begin
                  slot = seek_count;
                  n_tail++;
               end else begin
                  n_middle++;
               end
            end
            for (int i = seek_count; i > slot; i--)
               seek_queue[i] = seek_queue[i-1];
            seek_queue[slot] = pos;
            seek_count++;
         end
      end else if (seek_count > 0) begin
         r.position   = seek_queue[0];
         r.dispatched = 1'b1;
         last_served  = seek_queue[0];
         for (int i = 0; i + 1 < seek_count; i++)
            seek_queue[i] = seek_queue[i+1];
         seek_count--;
         n_pops++;
      end else begin
         n_empty_pops++;
      end
      return r;
   endfunction

   // Offer one request transaction; returns in the time step of its acceptance
   // with tvalid still high, so the next call can follow without a bubble.
   task automatic send_request(input op_type op, input pos_type pos,
                               input logic typed, input seek_result_type want);
      seek_result_type predicted;
      while (!steady && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= pos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = schedule_request(op, pos);
      pending_results.push_back(typed ? want : predicted);
   endtask

   // hold the request side off until every outstanding result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [47:0] want,
                                input logic [47:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= MAX_SHOWN)
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endtask

   // random sector positions: clustered around the head and queued entries so
   // that front and mid-queue insertion and ties come up, plus extremes and noise
   function automatic pos_type random_position();
      int      pick;
      pos_type anchor;
      pick = $urandom_range(99);
      if (pick < 25) begin
         anchor = (seek_count > 0 && $urandom_range(1)) ?
                  seek_queue[$urandom_range(seek_count - 1)] : last_served;
         return anchor + pos_type'($urandom_range(64)) - pos_type'(32);
      end else if (pick < 45) begin
         return pos_type'($urandom_range(63));
      end else if (pick < 55) begin
         case ($urandom_range(3))
            0: return '0;
            1: return pos_type'(1);
            2: return POS_MAX - 48'd1;
            default: return POS_MAX;
         endcase
      end
      return pos_type'({$urandom, $urandom});
   endfunction

   // Result side: random back-pressure, and each result transaction checked
   // against the oldest expectation.
   always @(posedge clock) begin : rsp_check
      seek_result_type want;
      rsp_tready <= steady || ($urandom_range(99) >= 12);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
               $display("%0t ns: unexpected result, position 0x%0h flags %b",
                        $time, rsp_tdata, rsp_tuser);
         end else begin
            want = pending_results.pop_front();
            compare_field("dispatched_position", want.position, rsp_tdata);
            compare_field("dispatch_valid", 48'(want.dispatched), 48'(rsp_tuser[0]));
            compare_field("add_rejected", 48'(want.rejected), 48'(rsp_tuser[1]));
         end
      end
   end

   initial begin
      int     add_bias;
      int     wait_cycles;
      op_type op;

      seek_count  = 0;
      last_served = '0;
      {n_front, n_middle, n_tail, n_refused, n_pops, n_empty_pops} = '0;

      // Directed table. Typed expectations: results straight after reset, the
      // extreme positions coming back out, and the refusal on a full queue.
      directed.push_back('{OP_DISPATCH, POS_MAX, 1'b1, RES_NONE});   // empty after reset
      directed.push_back('{OP_ADD, 48'h0, 1'b1, RES_NONE});
      directed.push_back('{OP_ADD, POS_MAX, 1'b1, RES_NONE});
      directed.push_back('{OP_DISPATCH, 48'h0, 1'b1, '{48'h0, 1'b1, 1'b0}});
      directed.push_back('{OP_DISPATCH, 48'h0, 1'b1, '{POS_MAX, 1'b1, 1'b0}});
      directed.push_back('{OP_DISPATCH, 48'h1, 1'b1, RES_NONE});      // emptied again
      // last position is now the top sector; build up a queue
      directed.push_back('{OP_ADD, 48'd1000, 1'b0, RES_NONE});        // into empty queue
      directed.push_back('{OP_ADD, 48'd2000, 1'b0, RES_NONE});        // nearer: front
      directed.push_back('{OP_ADD, 48'd1500, 1'b0, RES_NONE});        // mid-queue
      directed.push_back('{OP_ADD, 48'd2000, 1'b0, RES_NONE});        // tie with head
      directed.push_back('{OP_ADD, 48'd1000, 1'b0, RES_NONE});        // tie mid-queue: tail
      directed.push_back('{OP_ADD, 48'h0, 1'b0, RES_NONE});
      directed.push_back('{OP_ADD, 48'h1, 1'b0, RES_NONE});
      directed.push_back('{OP_ADD, 48'h7FFF_FFFF_FFFF, 1'b0, RES_NONE});
      directed.push_back('{OP_ADD, 48'h8000_0000_0000, 1'b0, RES_NONE});
      directed.push_back('{OP_ADD, 48'h5555_5555_5555, 1'b0, RES_NONE});
      directed.push_back('{OP_ADD, 48'hAAAA_AAAA_AAAA, 1'b0, RES_NONE});
      directed.push_back('{OP_ADD, POS_MAX, 1'b0, RES_NONE});
      directed.push_back('{OP_ADD, POS_MAX - 48'd1, 1'b0, RES_NONE});
      directed.push_back('{OP_ADD, 48'h0000_FFFF_0000, 1'b0, RES_NONE});
      directed.push_back('{OP_ADD, 48'd3000, 1'b0, RES_NONE});
      directed.push_back('{OP_ADD, 48'd1200, 1'b0, RES_NONE});        // sixteenth entry
      directed.push_back('{OP_ADD, 48'h1234, 1'b1, RES_REFUSE});      // queue full
      directed.push_back('{OP_DISPATCH, POS_MAX, 1'b0, RES_NONE});
      directed.push_back('{OP_DISPATCH, 48'h0, 1'b0, RES_NONE});

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_request(directed[i].op, directed[i].pos, directed[i].typed, directed[i].want);
      drain_results();

      // Random part: blocks of transactions leaning towards adds, balanced, or
      // towards dispatches, so the queue fills, refuses, and empties in turn.
      add_bias = 50;
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % 60 == 0)
            add_bias = 25 + 25 * $urandom_range(2);
         steady = (n >= 700 && n < 1000);
         if (n == 1000)
            drain_results();
         op = ($urandom_range(99) < add_bias) ? OP_ADD : OP_DISPATCH;
         send_request(op, random_position(), 1'b0, RES_NONE);
      end
      steady = 1'b0;

      // flush: wait out every result, then a few cycles for stray ones
      req_tvalid  <= 1'b0;
      wait_cycles = 0;
      while (pending_results.size() != 0 && wait_cycles < 10000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (12) @(posedge clock);
      if (pending_results.size() != 0) begin
         fail_count++;
         $display("%0t ns: %0d results never arrived", $time, pending_results.size());
      end

      $display("Covered %0d adds: %0d to the front, %0d mid-queue, %0d at the tail, %0d refused",
               n_front + n_middle + n_tail + n_refused, n_front, n_middle, n_tail, n_refused);
      $display("and %0d dispatches, %0d of them on an empty queue; %0d mismatches",
               n_pops + n_empty_pops, n_empty_pops, fail_count);
      if (fail_count == 0) begin
         $display("seek_distance_request_queue_top: match");
      end else begin
         $display("seek_distance_request_queue_top: mismatch");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("Timed out with %0d results outstanding", pending_results.size());
      $display("seek_distance_request_queue_top: mismatch");
      $finish;
   end

endmodule

FILE: files.f
rtl/sdrq_pkg.sv
rtl/sdrq_cell.sv
rtl/seek_distance_request_queue_top.sv
verif/seek_distance_request_queue_top_tb.sv
